>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the gas level block.
// No dependencies; files that assert include this header by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge while reset is released.
`define ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/glma_pkg.sv
// Shared types and constants of the gas level moving average block.
// No dependencies; used by every module of the block.
package glma_pkg;

    // Field widths.
    localparam int unsigned MV_W      = 12;
    localparam int unsigned SUPPLY_W  = 13;
    localparam int unsigned RES_W     = 10;
    localparam int unsigned LEVEL_W   = 5;
    localparam int unsigned OUT_Q_W   = 13;
    localparam int unsigned CFG_W     = 13;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned S_DATA_W  = 16;
    localparam int unsigned M_DATA_W  = 24;

    // Products of the ratio comparison.
    localparam int unsigned NUM_W = SUPPLY_W + RES_W;
    localparam int unsigned DEN_W = MV_W + RES_W;

    // Mean is in Q8 ppm.
    localparam int unsigned FRAC_BITS = 8;
    localparam int unsigned LEVEL_MAX = 20;

    // Gas levels in ppm.
    localparam logic [LEVEL_W-1:0] LEVEL_1PPM  = 5'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_5PPM  = 5'd5;
    localparam logic [LEVEL_W-1:0] LEVEL_10PPM = 5'd10;
    localparam logic [LEVEL_W-1:0] LEVEL_20PPM = 5'd20;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_LOAD_RES   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CLEAN_RES  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SUPPLY_MV  = 2'd2;

    // Configuration reset values.
    localparam logic [RES_W-1:0]    LOAD_RES_RST  = 10'd100;
    localparam logic [RES_W-1:0]    CLEAN_RES_RST = 10'd100;
    localparam logic [SUPPLY_W-1:0] SUPPLY_MV_RST = 13'd5000;

    // Level queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 2;

    // One classified level moving from front to queue or queue to back.
    typedef struct packed {
        logic               valid;
        logic [LEVEL_W-1:0] level;
    } level_beat_t;

    // Fill status of the level queue.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Back end sequencer.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_UPDATE,
        BK_DIVIDE,
        BK_DONE
    } back_state_t;

endpackage

>>> rtl/core/glma_front.sv
// Front end: configuration registers, input beat acceptance and level classification.
// Depends on glma_pkg.
module glma_front
    import glma_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [MV_W-1:0]       s_mv,
    input  queue_status_t         q_status,
    output level_beat_t           level_out
);

    logic [RES_W-1:0]    load_reg;
    logic [RES_W-1:0]    clean_reg;
    logic [SUPPLY_W-1:0] supply_reg;

    logic              hold_reg;
    logic              zero_reg;
    logic              above_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;

    logic                accept;
    logic                push;
    logic [SUPPLY_W-1:0] diff;
    logic [NUM_W-1:0]    num_prod;
    logic [DEN_W-1:0]    den_prod;
    logic [LEVEL_W-1:0]  level;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_reg   <= LOAD_RES_RST;
            clean_reg  <= CLEAN_RES_RST;
            supply_reg <= SUPPLY_MV_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_LOAD_RES:  load_reg   <= cfg_wdata[RES_W-1:0];
                CFG_CLEAN_RES: clean_reg  <= cfg_wdata[RES_W-1:0];
                CFG_SUPPLY_MV: supply_reg <= cfg_wdata[SUPPLY_W-1:0];
                default: ;
            endcase
        end
    end

    // One beat is held while its level waits for room in the queue.
    assign push     = hold_reg && !q_status.full;
    assign s_tready = !hold_reg || !q_status.full;
    assign accept   = s_tvalid && s_tready;

    // Numerator and denominator of the resistance ratio.
    assign diff     = supply_reg - {1'b0, s_mv};
    assign num_prod = {{RES_W{1'b0}}, diff} * {{SUPPLY_W{1'b0}}, load_reg};
    assign den_prod = {{RES_W{1'b0}}, s_mv} * {{MV_W{1'b0}}, clean_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= 1'b0;
        end else if (accept) begin
            hold_reg <= 1'b1;
        end else if (push) begin
            hold_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            zero_reg  <= (s_mv == '0);
            above_reg <= ({1'b0, s_mv} > supply_reg);
            num_reg   <= num_prod;
            den_reg   <= den_prod;
        end
    end

    // Compare the ratio against one half, one and two by cross-multiplication.
    always_comb begin
        if (zero_reg) begin
            level = LEVEL_20PPM;
        end else if (above_reg) begin
            level = LEVEL_1PPM;
        end else if ({num_reg, 1'b0} < {2'b00, den_reg}) begin
            level = LEVEL_1PPM;
        end else if (num_reg < {1'b0, den_reg}) begin
            level = LEVEL_5PPM;
        end else if ({1'b0, num_reg} < {1'b0, den_reg, 1'b0}) begin
            level = LEVEL_10PPM;
        end else begin
            level = LEVEL_20PPM;
        end
    end

    assign level_out.valid = hold_reg;
    assign level_out.level = level;

endmodule

>>> rtl/core/glma_queue.sv
// Short level queue that decouples the classifier from the averaging back end.
// Depends on glma_pkg.
module glma_queue
    import glma_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  level_beat_t   wr_beat,
    output queue_status_t status,
    input  logic          pop,
    output level_beat_t   rd_beat
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [LEVEL_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    logic push;
    logic take;

    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign push         = wr_beat.valid && !status.full;
    assign take         = pop && !status.empty;

    // Pointers wrap at the queue depth.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (take) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !take) begin
                count_reg <= count_reg + 1'b1;
            end else if (take && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_beat.level;
        end
    end

    assign rd_beat.valid = !status.empty;
    assign rd_beat.level = entry_reg[rd_ptr_reg];

endmodule

>>> rtl/core/glma_back.sv
// Back end: level ring with running sum, bit-serial mean divider and result register.
// Depends on glma_pkg.
module glma_back
    import glma_pkg::*;
#(
    parameter int unsigned WINDOW = 10
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  level_beat_t        q_beat,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_Q_W-1:0] m_mean,
    output logic [LEVEL_W-1:0] m_level
);

    localparam int unsigned SLOT_W = $clog2(WINDOW);
    localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
    localparam int unsigned SUM_W  = $clog2(LEVEL_MAX * WINDOW + 1);
    localparam int unsigned DIV_W  = SUM_W + FRAC_BITS;
    localparam int unsigned STEP_W = $clog2(DIV_W);

    back_state_t        state_reg, state_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               full_reg, full_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0]   dq_reg, dq_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               m_valid_reg, m_valid_next;
    logic [OUT_Q_W-1:0] mean_reg, mean_next;
    logic [LEVEL_W-1:0] out_level_reg, out_level_next;

    logic [LEVEL_W-1:0] ring [WINDOW];
    logic [LEVEL_W-1:0] rd_data_reg;
    logic               ring_we;

    logic [LEVEL_W-1:0] old_level;
    logic [SUM_W-1:0]   sum_upd;
    logic               slot_wrap;
    logic [CNT_W:0]     trial;
    logic [CNT_W:0]     trial_sub;
    logic               trial_ge;

    // Ring memory; the entry under the write slot is read every cycle.
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring[slot_reg] <= level_reg;
        end
        rd_data_reg <= ring[slot_reg];
    end

    // Before the ring first wraps, the entry being replaced was never written.
    assign old_level = full_reg ? rd_data_reg : '0;
    assign sum_upd   = sum_reg - SUM_W'(old_level) + SUM_W'(level_reg);
    assign slot_wrap = (slot_reg == SLOT_W'(WINDOW - 1));

    // One restoring division step: remainder takes the next dividend bit.
    assign trial     = {rem_reg, dq_reg[DIV_W-1]};
    assign trial_ge  = (trial >= {1'b0, cnt_reg});
    assign trial_sub = trial - {1'b0, cnt_reg};

    // Sequencer: next state and datapath updates.
    always_comb begin
        state_next     = state_reg;
        level_next     = level_reg;
        slot_next      = slot_reg;
        full_next      = full_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        dq_next        = dq_reg;
        step_next      = step_reg;
        mean_next      = mean_reg;
        out_level_next = out_level_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        q_pop          = 1'b0;
        ring_we        = 1'b0;

        case (state_reg)
            BK_IDLE: begin
                if (q_beat.valid) begin
                    q_pop      = 1'b1;
                    level_next = q_beat.level;
                    state_next = BK_UPDATE;
                end
            end
            BK_UPDATE: begin
                ring_we   = 1'b1;
                sum_next  = sum_upd;
                slot_next = slot_wrap ? '0 : slot_reg + 1'b1;
                if (slot_wrap) begin
                    full_next = 1'b1;
                end
                if (full_reg || slot_wrap) begin
                    cnt_next = CNT_W'(WINDOW);
                end else begin
                    cnt_next = CNT_W'(slot_reg) + 1'b1;
                end
                rem_next   = '0;
                dq_next    = {sum_upd, {FRAC_BITS{1'b0}}};
                step_next  = STEP_W'(DIV_W - 1);
                state_next = BK_DIVIDE;
            end
            BK_DIVIDE: begin
                rem_next = trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
                dq_next  = {dq_reg[DIV_W-2:0], trial_ge};
                if (step_reg == '0) begin
                    state_next = BK_DONE;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end
            BK_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    mean_next      = dq_reg[OUT_Q_W-1:0];
                    out_level_next = level_reg;
                    m_valid_next   = 1'b1;
                    state_next     = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            slot_reg    <= '0;
            full_reg    <= 1'b0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            slot_reg    <= slot_next;
            full_reg    <= full_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        level_reg     <= level_next;
        cnt_reg       <= cnt_next;
        rem_reg       <= rem_next;
        dq_reg        <= dq_next;
        step_reg      <= step_next;
        mean_reg      <= mean_next;
        out_level_reg <= out_level_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_mean   = mean_reg;
    assign m_level  = out_level_reg;

endmodule

>>> rtl/core/gas_level_moving_average.sv
// Top level of the gas level moving average block.
// Depends on glma_pkg, glma_front, glma_queue, glma_back and assert_macros.svh.
//
// Each input beat carries a sensor voltage in millivolts. The front end
// classifies it into a level of 1, 5, 10 or 20 ppm from the sensing
// resistance ratio, compared exactly against one half, one and two; the
// level then waits in a two-entry queue. The back end replaces the oldest
// ring entry, updates the running sum and divides it by the number of filled
// entries with a bit-serial divider, giving the mean in Q8 ppm, truncated.
// The front end registers an accepted beat and holds it until the queue has
// room for its level, so it overlaps with the back end. The back end takes a
// new level only after finishing the last, stepping through update, divide
// and done; its divider runs D = clog2(20*WINDOW+1) + 8 steps and sets the
// sustained rate. Configuration must be written only while the block holds no
// beat; the block itself does not enforce it.
`include "assert_macros.svh"

module gas_level_moving_average
    import glma_pkg::*;
#(
    parameter int unsigned WINDOW = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port.
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // [11:0] sensor_millivolts, rest zero
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata    // [12:0] filtered_ppm_q8, [17:13] instant_ppm
);

    level_beat_t        front_beat;
    level_beat_t        back_beat;
    queue_status_t      q_status;
    logic               q_pop;
    logic [OUT_Q_W-1:0] mean;
    logic [LEVEL_W-1:0] level;

    logic               level_legal;
    logic               mean_in_range;
    logic               q_blocked;
    logic               q_status_bad;

    glma_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_mv      (s_tdata[MV_W-1:0]),
        .q_status  (q_status),
        .level_out (front_beat)
    );

    glma_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_beat (front_beat),
        .status  (q_status),
        .pop     (q_pop),
        .rd_beat (back_beat)
    );

    glma_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_beat   (back_beat),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_mean   (mean),
        .m_level  (level)
    );

    // Pack the result fields, lowest field first.
    assign m_tdata = {{(M_DATA_W - OUT_Q_W - LEVEL_W){1'b0}}, level, mean};

    // Conditions watched by the assertions below.
    assign level_legal   = (level == LEVEL_1PPM) || (level == LEVEL_5PPM) ||
                           (level == LEVEL_10PPM) || (level == LEVEL_20PPM);
    assign mean_in_range = (mean <= OUT_Q_W'(LEVEL_MAX << FRAC_BITS));
    assign q_blocked     = front_beat.valid && q_status.full;
    assign q_status_bad  = q_status.full && q_status.empty;

    // A result always carries one of the four levels.
    `ASSERT_RST(a_level_legal, aclk, aresetn, m_tvalid |-> level_legal, "illegal result level")

    // The mean never exceeds the largest level in Q8.
    `ASSERT_RST(a_mean_range, aclk, aresetn, m_tvalid |-> mean_in_range, "mean above 20 ppm")

    // A held level with a full queue must stall the input.
    `ASSERT_RST(a_stall_full, aclk, aresetn, q_blocked |-> !s_tready, "no stall on full queue")

    // The queue is never both full and empty.
    `ASSERT_RST(a_queue_status, aclk, aresetn, !q_status_bad, "queue full and empty")

endmodule

>>> sim/testbench.sv
// Self-checking testbench for gas_level_moving_average.
// Depends on glma_pkg and the block's RTL. A scoreboard class predicts each
// level and window mean from the register settings; plain tasks drive the streams.
`timescale 1ns / 1ps

module testbench;
    import glma_pkg::*;

    localparam int unsigned WINDOW      = 10;
    localparam int unsigned RESET_CYCLES = 12;
    localparam int unsigned LONG_HOLD   = 400;
    localparam int unsigned SETTLE      = 4;
    localparam int unsigned TAIL        = 40;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RAND_PHASES = 8;
    localparam int unsigned PHASE_ITEMS = 55;
    // Register index with no register behind it; writes there are ignored.
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;

    // One expected reading: window mean in Q8 ppm and the sample's own level.
    typedef struct {
        logic [OUT_Q_W-1:0] mean_q8;
        logic [LEVEL_W-1:0] level;
    } reading_t;

    // Tracks the register settings and the level ring, and checks readings in order.
    class level_scoreboard;
        logic [RES_W-1:0]    load_res;
        logic [RES_W-1:0]    clean_res;
        logic [SUPPLY_W-1:0] supply_mv;
        logic [LEVEL_W-1:0]  ring [WINDOW];
        int unsigned         slot;
        bit                  full;
        int unsigned         level_sum;
        reading_t            expected_readings [$];
        int unsigned         errors;
        int unsigned         samples;
        int unsigned         readings;
        int unsigned         level_hits [4];

        function new();
            load_res  = LOAD_RES_RST;
            clean_res = CLEAN_RES_RST;
            supply_mv = SUPPLY_MV_RST;
            foreach (ring[i]) ring[i] = '0;
            slot      = 0;
            full      = 1'b0;
            level_sum = 0;
            errors    = 0;
            samples   = 0;
            readings  = 0;
            foreach (level_hits[i]) level_hits[i] = 0;
        endfunction

        function int unsigned pending();
            return expected_readings.size();
        endfunction

        function void note_config(logic [CFG_ADDR_W-1:0] addr, logic [CFG_W-1:0] value);
            case (addr)
                CFG_LOAD_RES:  load_res  = value[RES_W-1:0];
                CFG_CLEAN_RES: clean_res = value[RES_W-1:0];
                CFG_SUPPLY_MV: supply_mv = value[SUPPLY_W-1:0];
                default: ;
            endcase
        endfunction

        // Compare the resistance ratio against one half, one and two by
        // cross-multiplication, with no division.
        function logic [LEVEL_W-1:0] grade_level(logic [MV_W-1:0] mv);
            bit [31:0] num;
            bit [31:0] den;
            if (mv == 0) return LEVEL_20PPM;
            if (32'(mv) > 32'(supply_mv)) return LEVEL_1PPM;
            num = (32'(supply_mv) - 32'(mv)) * 32'(load_res);
            den = 32'(mv) * 32'(clean_res);
            if (2 * num < den) return LEVEL_1PPM;
            if (num < den) return LEVEL_5PPM;
            if (num < 2 * den) return LEVEL_10PPM;
            return LEVEL_20PPM;
        endfunction

        function void note_sample(logic [MV_W-1:0] mv);
            logic [LEVEL_W-1:0] lvl;
            int unsigned        count;
            reading_t           r;
            lvl = grade_level(mv);
            case (lvl)
                LEVEL_1PPM:  level_hits[0]++;
                LEVEL_5PPM:  level_hits[1]++;
                LEVEL_10PPM: level_hits[2]++;
                default:     level_hits[3]++;
            endcase
            // Replace the oldest entry and keep the running sum.
            level_sum  = level_sum - ring[slot] + lvl;
            ring[slot] = lvl;
            slot++;
            if (slot >= WINDOW) begin
                slot = 0;
                full = 1'b1;
            end
            count = full ? WINDOW : slot;
            if (count == 0) count = 1;
            r.mean_q8 = OUT_Q_W'((level_sum * 256) / count);
            r.level   = lvl;
            expected_readings.push_back(r);
            samples++;
        endfunction

        function void check_result(logic [M_DATA_W-1:0] data);
            reading_t           r;
            logic [OUT_Q_W-1:0] got_mean;
            logic [LEVEL_W-1:0] got_level;
            got_mean  = data[OUT_Q_W-1:0];
            got_level = data[OUT_Q_W +: LEVEL_W];
            readings++;
            if (expected_readings.size() == 0) begin
                $error("Result beat with no sample pending: filtered_ppm_q8 %0d, instant_ppm %0d",
                       got_mean, got_level);
                errors++;
                return;
            end
            r = expected_readings.pop_front();
            if (got_mean !== r.mean_q8) begin
                $error("filtered_ppm_q8: expected %0d, got %0d", r.mean_q8, got_mean);
                errors++;
            end
            if (got_level !== r.level) begin
                $error("instant_ppm: expected %0d, got %0d", r.level, got_level);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;   // [11:0] sensor_millivolts, rest zero
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;   // [12:0] filtered_ppm_q8, [17:13] instant_ppm

    level_scoreboard board = new();

    bit          long_hold_req = 1'b0;
    bit          pace_gaps     = 1'b1;
    int unsigned burst_left    = 0;
    int unsigned settings_used = 1;
    int unsigned ready_run     = 0;
    int unsigned ready_mode    = 0;
    int unsigned cycles        = 0;

    gas_level_moving_average #(
        .WINDOW(WINDOW)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Clock.
    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Run limit.
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Timeout after %0d cycles with %0d readings pending", cycles, board.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result monitor: every accepted beat is checked against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);
    end

    // Receiver: switches among stall patterns, plus one long hold-off on request.
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                long_hold_req = 1'b0;
            end else begin
                if (ready_run == 0) begin
                    ready_mode = $urandom_range(0, 3);
                    ready_run  = $urandom_range(5, 60);
                end
                ready_run--;
                case (ready_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 7) != 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Register write; the enable stays high until the caller lowers it.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        board.note_config(addr, value);
        @(negedge aclk);
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] load, input logic [CFG_W-1:0] clean,
                                  input logic [CFG_W-1:0] supply, input bit poke_spare);
        write_reg(CFG_LOAD_RES, load);
        write_reg(CFG_CLEAN_RES, clean);
        if (poke_spare) write_reg(CFG_SPARE, CFG_W'($urandom));
        write_reg(CFG_SUPPLY_MV, supply);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Offer one sample beat and wait until the block takes it.
    task automatic send_sample(input logic [MV_W-1:0] mv);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (pace_gaps && $urandom_range(0, 2) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(mv);
        do @(posedge aclk); while (!s_tready);
        board.note_sample(mv);
        @(negedge aclk);
    endtask

    // Stop offering and wait for every pending reading, then let the block settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (board.pending() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // Voltages spread over the field, near zero, near the supply, and near the three ratio
    // thresholds for the current settings.
    function automatic logic [MV_W-1:0] pick_millivolts();
        longint sup;
        longint ld;
        longint cl;
        longint den;
        longint mv;
        sup = board.supply_mv;
        ld  = board.load_res;
        cl  = board.clean_res;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: mv = $urandom_range(0, 4095);
            4:          mv = $urandom_range(0, 7);
            5:          mv = sup + longint'($urandom_range(0, 6)) - 3;
            default: begin
                den = 2 * ld + (longint'(1) << $urandom_range(0, 2)) * cl;
                if (den == 0) mv = $urandom_range(0, 4095);
                else mv = (2 * sup * ld) / den + longint'($urandom_range(0, 6)) - 3;
            end
        endcase
        if (mv < 0) mv = 0;
        if (mv > 4095) mv = 4095;
        return MV_W'(mv);
    endfunction

    function automatic logic [CFG_W-1:0] pick_resistance();
        case ($urandom_range(0, 9))
            0:       return 13'd1;
            1:       return 13'd1000;
            2:       return 13'd1023;
            3:       return 13'd0;
            4:       return CFG_W'($urandom);    // upper bits beyond the register
            default: return CFG_W'($urandom_range(1, 1000));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_supply();
        case ($urandom_range(0, 7))
            0:       return 13'd1000;
            1:       return 13'd6000;
            2:       return 13'd8191;
            3:       return CFG_W'($urandom);
            default: return CFG_W'($urandom_range(1000, 6000));
        endcase
    endfunction

    // Stimulus.
    initial begin
        logic [MV_W-1:0] reset_probe [11];
        reset_probe = '{12'd0, 12'd1, 12'd1666, 12'd1667, 12'd2048, 12'd2500, 12'd2501,
                        12'd3300, 12'd3333, 12'd3334, 12'd4095};

        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Register reset values: all four levels and their exact boundaries.
        pace_gaps = 1'b0;
        foreach (reset_probe[i]) send_sample(reset_probe[i]);
        wait_drained();

        // Low supply: voltage equal to and above the supply; a spare index write
        // and junk above the load register's width must both be ignored.
        apply_settings(13'h1C00 | 13'd1000, 13'd1000, 13'd1000, 1'b1);
        send_sample(12'd1000);
        send_sample(12'd1001);
        send_sample(12'd999);
        send_sample(12'd500);
        send_sample(12'd4095);
        wait_drained();

        // Zero load register: level one unless the voltage is zero.
        apply_settings(13'd0, 13'd100, 13'd5000, 1'b0);
        send_sample(12'd0);
        send_sample(12'd2000);
        wait_drained();

        // Zero clean-air register: no comparison holds.
        apply_settings(13'd100, 13'd0, 13'd5000, 1'b0);
        send_sample(12'd1);
        send_sample(12'd3000);
        wait_drained();

        // Random phases, the first two at the register extremes.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0:       apply_settings(13'd1, 13'd1000, 13'd6000, 1'b0);
                1:       apply_settings(13'd1000, 13'd1, 13'd1000, 1'b0);
                default: apply_settings(pick_resistance(), pick_resistance(), pick_supply(),
                                        $urandom_range(0, 3) == 0);
            endcase
            pace_gaps  = (ph % 3 != 0);
            burst_left = 0;
            // Receiver holds off while the sender keeps offering beats.
            if (ph == 3) begin
                pace_gaps     = 1'b0;
                long_hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 5 && n == PHASE_ITEMS / 2) wait_drained();
                send_sample(pick_millivolts());
            end
            wait_drained();
        end

        repeat (TAIL) @(negedge aclk);
        $display("Sent %0d sensor samples under %0d register settings; %0d readings checked.",
                 board.samples, settings_used, board.readings);
        $display("Levels 1/5/10/20 ppm seen %0d/%0d/%0d/%0d times, with one %0d-cycle hold-off.",
                 board.level_hits[0], board.level_hits[1], board.level_hits[2],
                 board.level_hits[3], LONG_HOLD);
        if (board.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/glma_pkg.sv
rtl/core/glma_front.sv
rtl/core/glma_queue.sv
rtl/core/glma_back.sv
rtl/core/gas_level_moving_average.sv
sim/testbench.sv
